@@ rtl/core/acsas_pkg.sv @@
`timescale 1ns / 1ps
package acsas_pkg;
    localparam int DEF_NUM_WINDOWS = 4;
    localparam int MAX_REPORT = 4;
    localparam logic [15:0] CAL_LOW_RESET = 16'h0002;
    localparam logic [15:0] CAL_HIGH_RESET = 16'h587A;
    localparam logic signed [31:0] RANGE_HIGH_RESET = 32'sd6553600;

    typedef enum logic [2:0] {
        REG_SENSOR_MODE = 3'd0,
        REG_CAL_LOW     = 3'd1,
        REG_CAL_HIGH    = 3'd2,
        REG_RANGE_LOW   = 3'd3,
        REG_RANGE_HIGH  = 3'd4,
        REG_ALARM_LOW   = 3'd5,
        REG_ALARM_HIGH  = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        ALARM_NORMAL = 2'd0,
        ALARM_LOW    = 2'd1,
        ALARM_HIGH   = 2'd2
    } alarm_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_START, ST_DIV, ST_CLAMP, ST_RD, ST_WAIT, ST_UPD,
        ST_AVG, ST_OUT, ST_CLR
    } state_t;

    // Window record as held in memory: count, min, max, sum
    localparam int REC_W = 160;
endpackage

@@ rtl/core/acsas_ram.sv @@
`timescale 1ns / 1ps
module acsas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/acsas_div.sv @@
`timescale 1ns / 1ps
module acsas_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic signed [63:0] divisor,
    output logic               busy,
    output logic signed [63:0] quotient
);
    logic [63:0] num_reg, num_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        neg_reg;
    logic [64:0] trial;

    // Restoring divide on magnitudes, one bit per cycle
    always_comb begin
        trial    = {rem_reg, num_reg[63]} - {1'b0, den_reg};
        num_next = {num_reg[62:0], ~trial[64]};
        rem_next = trial[64] ? {rem_reg[62:0], num_reg[63]} : trial[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 7'd64;
        end else if (cnt_reg != 7'd0) begin
            cnt_reg <= cnt_reg - 7'd1;
        end
        if (start) begin
            num_reg <= dividend[63] ? 64'(-dividend) : dividend;
            den_reg <= divisor[63] ? 64'(-divisor) : divisor;
            rem_reg <= '0;
            neg_reg <= dividend[63] ^ divisor[63];
        end else if (cnt_reg != 7'd0) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = (cnt_reg != 7'd0);
    assign quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);
endmodule

@@ rtl/core/analog_channel_scale_alarm_stats.sv @@
`timescale 1ns / 1ps
// Sequence: a sample is scaled through a serial divide, then for each window its record is read,
// updated and written back and its average taken through a second serial divide; a result is
// offered for each reported window.
// Flow: one item at a time; no new sample or clear is taken until the last one is through. The
// serial divider is shared between scaling and averaging.
// Reset: synchronous active-low aresetn restores the register defaults and clears
// all windows through a sweep, during which no item is taken.
module analog_channel_scale_alarm_stats #(
    parameter int NUM_WINDOWS = acsas_pkg::DEF_NUM_WINDOWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // raw_sample[15:0]
    input  logic [2:0]  s_tuser,   // kind[0], clear_window[2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [167:0] m_tdata,  // converted_value, alarm_state, window_index, sample_count,
                                   // window_min, window_max, window_average, zero pad
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import acsas_pkg::*;

    localparam int WW = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int NREP = (NUM_WINDOWS < MAX_REPORT) ? NUM_WINDOWS : MAX_REPORT;

    logic               mode_reg;
    logic [15:0]        cal_low_reg, cal_high_reg;
    logic signed [31:0] rlo_reg, rhi_reg, alo_reg, ahi_reg;

    state_t state_reg, state_next;
    logic [WW:0]        win_reg;
    logic [WW:0]        clr_reg;
    logic [15:0]        raw_reg;
    logic [1:0]         cw_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] val_reg;
    logic [1:0]         alarm_reg;
    logic [REC_W-1:0]   rec_reg;
    logic               mode_low_reg, mode_high_reg;

    logic               div_start, div_busy;
    logic signed [63:0] div_a, div_b, div_q;

    logic               ram_we;
    logic [WW-1:0]      ram_waddr, ram_raddr;
    logic [REC_W-1:0]   ram_wdata, ram_rdata;

    logic signed [17:0] span;
    logic signed [32:0] diff;
    logic signed [19:0] r5;
    logic signed [19:0] mnum;
    logic signed [64:0] vfull;
    logic signed [31:0] lo_lim, hi_lim;

    logic [31:0]        r_cnt;
    logic signed [31:0] r_min, r_max, n_min, n_max;
    logic signed [63:0] r_sum, n_sum;
    logic signed [64:0] sum_w;
    logic [31:0]        n_cnt;
    logic signed [31:0] avg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && (clr_reg == '0);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b0;
            cal_low_reg  <= CAL_LOW_RESET;
            cal_high_reg <= CAL_HIGH_RESET;
            rlo_reg      <= '0;
            rhi_reg      <= RANGE_HIGH_RESET;
            alo_reg      <= '0;
            ahi_reg      <= RANGE_HIGH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SENSOR_MODE: mode_reg     <= cfg_data[0];
                REG_CAL_LOW:     cal_low_reg  <= cfg_data[15:0];
                REG_CAL_HIGH:    cal_high_reg <= cfg_data[15:0];
                REG_RANGE_LOW:   rlo_reg      <= cfg_data;
                REG_RANGE_HIGH:  rhi_reg      <= cfg_data;
                REG_ALARM_LOW:   alo_reg      <= cfg_data;
                REG_ALARM_HIGH:  ahi_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Scaling terms
    always_comb begin
        span  = $signed({2'b0, cal_high_reg}) - $signed({2'b0, cal_low_reg});
        diff  = $signed({rhi_reg[31], rhi_reg}) - $signed({rlo_reg[31], rlo_reg});
        r5    = $signed({4'b0, raw_reg}) * 20'sd5;
        mnum  = mode_reg ? 20'($signed({4'b0, raw_reg}) - $signed({4'b0, cal_low_reg}))
                         : 20'(r5 - 20'(span));
        div_a = prod_reg;
        div_b = mode_reg ? 64'(span) : 64'(span) * 64'sd4;
        vfull = 65'(rlo_reg) + 65'(div_q);
        lo_lim = (alo_reg < rlo_reg) ? rlo_reg : alo_reg;
        hi_lim = (ahi_reg > rhi_reg) ? rhi_reg : ahi_reg;
    end

    // Window record update
    always_comb begin
        r_cnt = rec_reg[31:0];
        r_min = rec_reg[63:32];
        r_max = rec_reg[95:64];
        r_sum = rec_reg[159:96];
        if (r_cnt == '0) begin
            n_min = val_reg;
            n_max = val_reg;
        end else begin
            n_min = (val_reg < r_min) ? val_reg : r_min;
            n_max = (val_reg > r_max) ? val_reg : r_max;
        end
        n_cnt = (r_cnt == '1) ? r_cnt : r_cnt + 32'd1;
        sum_w = 65'(r_sum) + 65'(val_reg);
        if (sum_w[64] != sum_w[63]) begin
            n_sum = sum_w[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
            n_sum = sum_w[63:0];
        end
        if (r_cnt == '0) begin
            avg = '0;
        end else if (div_q > 64'sd2147483647) begin
            avg = 32'sh7FFFFFFF;
        end else if (div_q < -64'sd2147483648) begin
            avg = 32'sh80000000;
        end else begin
            avg = div_q[31:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = win_reg[WW-1:0];
        ram_raddr  = win_reg[WW-1:0];
        ram_wdata  = {n_sum, n_max, n_min, n_cnt};
        if (clr_reg != '0) begin
            ram_we    = 1'b1;
            ram_waddr = WW'(clr_reg - 1'b1);
            ram_wdata = '0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tuser[0]) begin
                        state_next = (32'(s_tuser[2:1]) < NUM_WINDOWS) ? ST_CLR : ST_IDLE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: state_next = ST_START;
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = ST_RD;
            ST_RD:    state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_UPD;
            ST_UPD: begin
                ram_we     = 1'b1;
                div_start  = 1'b1;
                state_next = ST_AVG;
            end
            ST_AVG: begin
                if (!div_busy) begin
                    state_next = (32'(win_reg) < NREP) ? ST_OUT : ST_RD;
                    if (32'(win_reg) >= NREP && 32'(win_reg) + 1 >= NUM_WINDOWS) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = (32'(win_reg) + 1 >= NUM_WINDOWS) ? ST_IDLE : ST_RD;
                end
            end
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = WW'(cw_reg);
                ram_wdata = '0;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            clr_reg   <= (WW+1)'(NUM_WINDOWS);
        end else begin
            state_reg <= state_next;
            if (clr_reg != '0) begin
                clr_reg <= clr_reg - 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid && s_tready) begin
            cw_reg   <= s_tuser[2:1];
            raw_reg  <= s_tdata;
            win_reg  <= '0;
        end
        if (state_reg == ST_MUL) begin
            prod_reg      <= 64'(diff) * 64'(mnum);
            mode_low_reg  <= (mode_reg == 1'b0) && (r5 < 20'(span));
            mode_high_reg <= (mode_reg == 1'b0) && ({2'b0, raw_reg} > {2'b0, cal_high_reg});
        end
        if (state_reg == ST_CLAMP) begin
            logic signed [64:0] v;
            v = vfull;
            if (mode_low_reg || span == 18'sd0) begin
                v = 65'(rlo_reg);
            end
            if (!mode_low_reg && mode_high_reg) begin
                v = 65'(rhi_reg);
            end
            if (v > 65'(rhi_reg)) begin
                v = 65'(rhi_reg);
            end else if (v < 65'(rlo_reg)) begin
                v = 65'(rlo_reg);
            end
            val_reg <= v[31:0];
            if ($signed(v[31:0]) < lo_lim) begin
                alarm_reg <= ALARM_LOW;
            end else if ($signed(v[31:0]) > hi_lim) begin
                alarm_reg <= ALARM_HIGH;
            end else begin
                alarm_reg <= ALARM_NORMAL;
            end
        end
        if (state_reg == ST_WAIT) begin
            rec_reg <= ram_rdata;
        end
        if (state_reg == ST_UPD) begin
            rec_reg <= {n_sum, n_max, n_min, n_cnt};
        end
        if (state_reg == ST_AVG && !div_busy && 32'(win_reg) >= NREP) begin
            win_reg <= win_reg + 1'b1;
        end
        if (state_reg == ST_OUT && m_tready) begin
            win_reg <= win_reg + 1'b1;
        end
    end

    acsas_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (state_reg == ST_UPD ? n_sum : div_a),
        .divisor  (state_reg == ST_UPD ? 64'(n_cnt) : div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    acsas_ram #(.WIDTH(REC_W), .DEPTH(1 << WW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output channel
    always_comb begin
        m_tvalid = (state_reg == ST_OUT) || (state_reg == ST_CLR);
        if (state_reg == ST_CLR) begin
            m_tdata = {4'b0, 128'b0, cw_reg, ALARM_NORMAL, 32'b0};
            m_tlast = 1'b1;
        end else begin
            m_tdata = {4'b0, avg, rec_reg[95:64], rec_reg[63:32], rec_reg[31:0],
                       win_reg[1:0], alarm_reg, val_reg};
            m_tlast = (32'(win_reg) + 1 >= NREP);
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    a_clear_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (clr_reg != '0) |-> (state_reg == ST_IDLE))
        else $error("work during clear sweep");
`endif
endmodule
